// ===== rtl/mmt_pkg.sv =====
`timescale 1ns / 1ps

package mmt_pkg;

    // Lane and word geometry of the step and result words.
    localparam int LANE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int WORD_W    = 64;
    localparam int ACC_W     = 32;
    localparam int POS_W     = 3;
    localparam int MAX_LANES = WORD_W / LANE_W;

    // Configuration port geometry and register map.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_WEIGHT_MODE = 1'b0;

    // Weight format codes.
    localparam logic MODE_INT8 = 1'b0;
    localparam logic MODE_INT4 = 1'b1;

    // Step queue between the decoder and the accumulator array.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One decoded K step: both operand sets as signed bytes per lane.
    typedef struct packed {
        logic [WORD_W-1:0] act;
        logic [WORD_W-1:0] wt;
        logic              last;
    } t_step;

endpackage

// ===== rtl/mmt_if.sv =====
`timescale 1ns / 1ps

// Step channel: one K step of activations and weights.
interface mmt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] activation_lanes;
    logic [63:0] weight_lanes;
    logic        last_step;

    modport source (output valid, output activation_lanes, output weight_lanes,
                    output last_step, input ready);
    modport sink   (input valid, input activation_lanes, input weight_lanes,
                    input last_step, output ready);
endinterface

// Result channel: one accumulator with its tile position.
interface mmt_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         row_index;
    logic [2:0]         column_index;
    logic signed [31:0] dot_sum;
    logic               last_of_tile;

    modport source (output valid, output row_index, output column_index,
                    output dot_sum, output last_of_tile, input ready);
    modport sink   (input valid, input row_index, input column_index,
                    input dot_sum, input last_of_tile, output ready);
endinterface

// ===== rtl/mmt_front.sv =====
`timescale 1ns / 1ps

module mmt_front #(
    parameter int TILE = 8
) (
    mmt_in_if.sink         i_in,
    input  logic           i_weight_mode,
    output logic           o_push_valid,
    output mmt_pkg::t_step o_push_step,
    input  logic           i_push_ready
);
    import mmt_pkg::*;

    // The word is accepted whenever the step queue has room.
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign o_push_step.last = i_in.last_step;

    // Unpack lanes: activations pass as bytes, weights pass as bytes or, in 4-bit mode, are sign-extended to bytes.
    for (genvar j = 0; j < MAX_LANES; j++) begin : g_lane
        if (j < TILE) begin : g_used
            logic [NIB_W-1:0] w_nib;
            assign w_nib = i_in.weight_lanes[NIB_W*j +: NIB_W];
            assign o_push_step.act[LANE_W*j +: LANE_W] =
                i_in.activation_lanes[LANE_W*j +: LANE_W];
            assign o_push_step.wt[LANE_W*j +: LANE_W] = (i_weight_mode == MODE_INT4)
                ? {{(LANE_W-NIB_W){w_nib[NIB_W-1]}}, w_nib}
                : i_in.weight_lanes[LANE_W*j +: LANE_W];
        end else begin : g_unused
            assign o_push_step.act[LANE_W*j +: LANE_W] = '0;
            assign o_push_step.wt[LANE_W*j +: LANE_W]  = '0;
        end
    end

endmodule

// ===== rtl/mmt_queue.sv =====
`timescale 1ns / 1ps

module mmt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  mmt_pkg::t_step i_push_step,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output mmt_pkg::t_step o_pop_step,
    input  logic           i_pop_ready
);
    import mmt_pkg::*;

    t_step              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_step   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage for queued steps.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_step;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/mmt_array.sv =====
`timescale 1ns / 1ps

module mmt_array #(
    parameter int TILE = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  mmt_pkg::t_step                    i_step,
    output logic                              o_ready,
    output logic                              o_cap_valid,
    output logic [TILE*TILE*mmt_pkg::ACC_W-1:0] o_cap_sums,
    input  logic                              i_cap_ready
);
    import mmt_pkg::*;

    localparam int N = TILE * TILE;

    logic [ACC_W-1:0] r_acc [N];
    logic             w_take;

    // A closing step waits until the drain bank is free to take the sums.
    assign o_ready     = !i_step.last || i_cap_ready;
    assign w_take      = i_valid && o_ready;
    assign o_cap_valid = w_take && i_step.last;

    // One multiply-accumulate cell for every row and column.
    for (genvar r = 0; r < TILE; r++) begin : g_row
        for (genvar c = 0; c < TILE; c++) begin : g_col
            logic signed [2*LANE_W-1:0] w_prod;
            logic [ACC_W-1:0]           w_sum;

            assign w_prod = $signed(i_step.act[LANE_W*r +: LANE_W])
                          * $signed(i_step.wt[LANE_W*c +: LANE_W]);
            assign w_sum = r_acc[r*TILE+c]
                         + {{(ACC_W-2*LANE_W){w_prod[2*LANE_W-1]}}, w_prod};
            assign o_cap_sums[ACC_W*(r*TILE+c) +: ACC_W] = w_sum;

            // The sum moves to the drain bank on the closing step.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_acc[r*TILE+c] <= '0;
                end else if (w_take) begin
                    r_acc[r*TILE+c] <= i_step.last ? '0 : w_sum;
                end
            end
        end
    end

endmodule

// ===== rtl/mmt_drain.sv =====
`timescale 1ns / 1ps

module mmt_drain #(
    parameter int TILE = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cap_valid,
    input  logic [TILE*TILE*mmt_pkg::ACC_W-1:0] i_cap_sums,
    output logic                                o_cap_ready,
    mmt_out_if.source                           o_out
);
    import mmt_pkg::*;

    localparam int N    = TILE * TILE;
    localparam int RC_W = $clog2(TILE);

    logic [ACC_W-1:0] r_bank [N];
    logic             r_busy;
    logic [RC_W-1:0]  r_row;
    logic [RC_W-1:0]  r_col;
    logic             r_ovalid;
    logic [POS_W-1:0] r_orow;
    logic [POS_W-1:0] r_ocol;
    logic [ACC_W-1:0] r_osum;
    logic             r_olast;
    logic             w_adv;
    logic             w_row_end;
    logic             w_tile_end;

    assign o_cap_ready = !r_busy;
    assign w_adv       = r_busy && (!r_ovalid || o_out.ready);
    assign w_row_end   = (r_col == RC_W'(TILE - 1));
    assign w_tile_end  = w_row_end && (r_row == RC_W'(TILE - 1));

    // Drain bank: loaded in one go, shifted out toward entry zero.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (i_cap_valid && !r_busy) begin
                r_bank[k] <= i_cap_sums[ACC_W*k +: ACC_W];
            end else if (w_adv && (k < N - 1)) begin
                r_bank[k] <= r_bank[(k + 1) % N];
            end
        end
    end

    // Row and column walk in row-major order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cap_valid && !r_busy) begin
            r_busy <= 1'b1;
            r_row  <= '0;
            r_col  <= '0;
        end else if (w_adv) begin
            if (w_tile_end) begin
                r_busy <= 1'b0;
            end
            if (w_row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_orow  <= POS_W'(r_row);
            r_ocol  <= POS_W'(r_col);
            r_osum  <= r_bank[0];
            r_olast <= w_tile_end;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.row_index    = r_orow;
    assign o_out.column_index = r_ocol;
    assign o_out.dot_sum      = $signed(r_osum);
    assign o_out.last_of_tile = r_olast;

endmodule

// ===== rtl/int8_int4_matmul_tile.sv =====
`timescale 1ns / 1ps

// Output-stationary integer GEMM tile. Each input word is one K step: TILE
// signed 8-bit activations (one per tile row) and TILE weights (one per
// column), either signed bytes or packed signed nibbles as set by the
// weight_mode register at address 0. Steps enter the array of TILE*TILE
// multiply-accumulate cells at one word per cycle unless a closing step
// waits. The step flagged last_step is added, then all TILE*TILE sums move
// into a drain bank, the accumulators restart from zero, and the bank emits
// the sums in row-major order, one word per cycle while the receiver is
// ready, the final one flagged last_of_tile. Accumulation of the next tile
// runs while the bank drains; only the next closing step waits, until the
// previous tile's TILE*TILE words have left the bank. A two-entry queue
// sits between the lane decoder and the array. Sums wrap modulo 2^32.
module int8_int4_matmul_tile #(
    parameter int TILE = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mmt_in_if.sink                           i_in,
    mmt_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmt_pkg::PADDR_W-1:0]      paddr,
    input  logic [mmt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mmt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import mmt_pkg::*;

    logic                      r_weight_mode;
    logic                      w_sel_mode;
    logic                      w_push_valid;
    t_step                     w_push_step;
    logic                      w_push_ready;
    logic                      w_pop_valid;
    t_step                     w_pop_step;
    logic                      w_pop_ready;
    logic                      w_cap_valid;
    logic [TILE*TILE*ACC_W-1:0] w_cap_sums;
    logic                      w_cap_ready;

    // Register file: one mode bit, decoded by word address.
    assign pready     = 1'b1;
    assign w_sel_mode = (paddr[PADDR_W-1] == REG_WEIGHT_MODE);
    assign prdata     = w_sel_mode ? {{(APB_DATA_W-1){1'b0}}, r_weight_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_mode <= MODE_INT8;
        end else if (psel && penable && pwrite && pready && w_sel_mode) begin
            r_weight_mode <= pwdata[0];
        end
    end

    // Front: lane decode.
    mmt_front #(.TILE(TILE)) u_front (
        .i_in          (i_in),
        .i_weight_mode (r_weight_mode),
        .o_push_valid  (w_push_valid),
        .o_push_step   (w_push_step),
        .i_push_ready  (w_push_ready)
    );

    // Step queue.
    mmt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_step  (w_push_step),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_step   (w_pop_step),
        .i_pop_ready  (w_pop_ready)
    );

    // Back: accumulator array.
    mmt_array #(.TILE(TILE)) u_array (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_pop_valid),
        .i_step      (w_pop_step),
        .o_ready     (w_pop_ready),
        .o_cap_valid (w_cap_valid),
        .o_cap_sums  (w_cap_sums),
        .i_cap_ready (w_cap_ready)
    );

    // Back: result drain.
    mmt_drain #(.TILE(TILE)) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap_valid (w_cap_valid),
        .i_cap_sums  (w_cap_sums),
        .o_cap_ready (w_cap_ready),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/mmt_checker.sv =====
`timescale 1ns / 1ps

module mmt_checker #(
    parameter int TILE = 8
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mmt_pkg::POS_W-1:0]  i_row,
    input logic [mmt_pkg::POS_W-1:0]  i_col,
    input logic [mmt_pkg::ACC_W-1:0]  i_sum,
    input logic                       i_last
);
    import mmt_pkg::*;

    // A stalled result word stays up unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_row, i_col, i_sum, i_last}))
        else $error("result word changed while stalled");

    // The tile run ends exactly at the bottom-right accumulator.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == ((i_row == POS_W'(TILE - 1))
            && (i_col == POS_W'(TILE - 1)))))
        else $error("last_of_tile flag at wrong position");

    // Positions stay inside the tile.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_row) < TILE) && (int'(i_col) < TILE))
        else $error("result position outside the tile");

    // Within a row the next word follows at once, one column further.
    a_col_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_col != POS_W'(TILE - 1))
            |=> i_out_valid && (i_row == $past(i_row))
            && (i_col == $past(i_col) + 1'b1))
        else $error("column walk out of order");

endmodule

bind int8_int4_matmul_tile mmt_checker #(.TILE(TILE)) u_mmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_row       (o_out.row_index),
    .i_col       (o_out.column_index),
    .i_sum       (o_out.dot_sum),
    .i_last      (o_out.last_of_tile)
);

// ===== sim/int8_int4_matmul_tile_tb.sv =====
`timescale 1ns / 1ps

module int8_int4_matmul_tile_tb;
    import mmt_pkg::*;

    localparam int TILE           = 8;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 64;

    localparam logic [PADDR_W-1:0] ADDR_WEIGHT_MODE = PADDR_W'(4 * REG_WEIGHT_MODE);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = PADDR_W'(4);

    // One expected accumulator word as it should leave the result channel.
    typedef struct {
        logic [2:0]  row;
        logic [2:0]  column;
        logic [31:0] sum;
        logic        last;
    } t_tile_sum;

    // Tracks the accumulator store and holds the sums still to be drained.
    class tile_scoreboard;
        logic [31:0] acc_store [TILE*TILE];
        logic        weight_mode;
        t_tile_sum   expected_sums [$];
        int          errors;

        function new();
            foreach (acc_store[i]) acc_store[i] = '0;
            weight_mode = MODE_INT8;
            errors      = 0;
        endfunction

        function void set_mode(logic mode);
            weight_mode = mode;
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        function int lane_weight(logic [63:0] wt, int col);
            if (weight_mode == MODE_INT4)
                return int'($signed(wt[4*col +: 4]));
            return int'($signed(wt[8*col +: 8]));
        endfunction

        // Add one K step into the store; a closing step queues the whole tile.
        function void note_step(logic [63:0] act, logic [63:0] wt, logic last);
            int        a;
            int        w;
            t_tile_sum item;
            for (int r = 0; r < TILE; r++) begin
                a = int'($signed(act[8*r +: 8]));
                for (int c = 0; c < TILE; c++) begin
                    w = lane_weight(wt, c);
                    acc_store[r*TILE + c] += 32'(a * w);
                end
            end
            if (last) begin
                for (int r = 0; r < TILE; r++) begin
                    for (int c = 0; c < TILE; c++) begin
                        item.row    = 3'(r);
                        item.column = 3'(c);
                        item.sum    = acc_store[r*TILE + c];
                        item.last   = (r == TILE - 1) && (c == TILE - 1);
                        expected_sums.push_back(item);
                        acc_store[r*TILE + c] = '0;
                    end
                end
            end
        endfunction

        function void check_result(logic [2:0] row, logic [2:0] column,
                                   logic [31:0] sum, logic last);
            t_tile_sum item;
            if (expected_sums.size() == 0) begin
                $error("unexpected result word at row %0d column %0d", row, column);
                errors++;
                return;
            end
            item = expected_sums.pop_front();
            if (row !== item.row) begin
                $error("row_index: expected %0d, actual %0d", item.row, row);
                errors++;
            end
            if (column !== item.column) begin
                $error("column_index: expected %0d, actual %0d", item.column, column);
                errors++;
            end
            if (sum !== item.sum) begin
                $error("dot_sum: expected %0d, actual %0d",
                       $signed(item.sum), $signed(sum));
                errors++;
            end
            if (last !== item.last) begin
                $error("last_of_tile: expected %0d, actual %0d", item.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mmt_in_if  in_ch ();
    mmt_out_if out_ch ();

    tile_scoreboard sb;
    int             src_idle_pct;
    int             snk_idle_pct;
    bit             hold_request;

    int8_int4_matmul_tile #(
        .TILE(TILE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Lane pattern that favors the signed extremes of each byte.
    function automatic logic [63:0] rand_lanes();
        logic [63:0] v;
        if ($urandom_range(0, 1))
            return {$urandom(), $urandom()};
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 5))
                0: v[8*i +: 8] = 8'h7f;
                1: v[8*i +: 8] = 8'h80;
                2: v[8*i +: 8] = 8'hff;
                3: v[8*i +: 8] = 8'h00;
                default: v[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return v;
    endfunction

    // APB write: setup cycle, then access cycle until pready.
    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_WEIGHT_MODE)
            sb.set_mode(data[0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // APB read of the mode register, compared with the tracked value.
    task automatic check_mode_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WEIGHT_MODE;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_W'(sb.weight_mode)) begin
            $error("weight_mode: expected %0d, actual %0d", sb.weight_mode, prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_weight_mode(logic mode);
        logic [APB_DATA_W-1:0] data;
        data    = $urandom();
        data[0] = mode;
        reg_write(ADDR_WEIGHT_MODE, data);
        check_mode_readback();
    endtask

    // Offer one K step, with random gaps ahead of it, and wait for acceptance.
    task automatic send_step(logic [63:0] act, logic [63:0] wt, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.activation_lanes <= act;
        in_ch.weight_lanes     <= wt;
        in_ch.last_step        <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_step(act, wt, last);
    endtask

    // Let every queued sum drain, then give the step queue time to empty.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random tiles, mostly short, some with a mode change halfway through.
    task automatic run_random(int n_items);
        int  sent;
        int  k_len;
        bit  split;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                if ($urandom_range(0, 2) == 0)
                    reg_write(ADDR_UNMAPPED, $urandom());
                set_weight_mode(1'($urandom_range(0, 1)));
            end
            k_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70)
                                                : $urandom_range(1, 6);
            split = (k_len > 1) && ($urandom_range(0, 4) == 0);
            for (int k = 0; k < k_len; k++) begin
                if (split && k == k_len / 2) begin
                    wait_idle();
                    set_weight_mode(~sb.weight_mode);
                end
                send_step(rand_lanes(), rand_lanes(), k == k_len - 1);
                sent++;
            end
        end
    endtask

    // Result side: check each accepted word, then pick the next ready level.
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left    = 0;
        hold_seen    = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready)
                sb.check_result(out_ch.row_index, out_ch.column_index,
                                out_ch.dot_sum, out_ch.last_of_tile);
            if (hold_request && !hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = 1'b1;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog: too long without any word moving on either channel.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("int8_int4_matmul_tile_tb failed");
        $finish;
    end

    initial begin
        sb = new();
        src_idle_pct = 18;
        snk_idle_pct = 71;
        hold_request = 1'b0;

        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.activation_lanes <= '0;
        in_ch.weight_lanes     <= '0;
        in_ch.last_step        <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of the mode register.
        check_mode_readback();

        // Signed byte extremes in 8-bit mode.
        send_step(64'h7f7f_7f7f_7f7f_7f7f, 64'h7f7f_7f7f_7f7f_7f7f, 1'b0);
        send_step(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080, 1'b0);
        send_step(64'h8080_8080_8080_8080, 64'h7f7f_7f7f_7f7f_7f7f, 1'b1);
        // A tile of one all-zero step drains zeros.
        send_step(64'h0, 64'h0, 1'b1);
        // Distinct values per lane expose lane swaps.
        send_step(64'h80ff_7f01_0040_c0fe, 64'h0102_0304_fcfd_feff, 1'b0);
        send_step(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b1);

        // A write to an unmapped address leaves the mode alone.
        wait_idle();
        reg_write(ADDR_UNMAPPED, 32'hffff_ffff);
        check_mode_readback();
        send_step(rand_lanes(), 64'hffff_ffff_ffff_ffff, 1'b1);

        // Nibble extremes in 4-bit mode; the upper half of the weights is ignored.
        wait_idle();
        set_weight_mode(MODE_INT4);
        send_step(64'h7f7f_7f7f_7f7f_7f7f, 64'hffff_ffff_7777_7777, 1'b0);
        send_step(64'h8080_8080_8080_8080, 64'h0000_0000_8888_8888, 1'b0);
        send_step(64'h8080_7f7f_01ff_0080, 64'hdead_beef_f0f0_8787, 1'b1);
        send_step(64'h7f80_ff01_807f_01ff, 64'h1234_5678_0f1e_2d3c, 1'b1);

        // A mode change in the middle of a tile keeps the partial sums.
        send_step(rand_lanes(), 64'h5a5a_5a5a_9abc_def0, 1'b0);
        wait_idle();
        set_weight_mode(MODE_INT8);
        send_step(rand_lanes(), 64'h9abc_def0_1234_5678, 1'b0);
        wait_idle();
        set_weight_mode(MODE_INT4);
        send_step(rand_lanes(), 64'h0f0f_0f0f_f7f7_8080, 1'b1);

        run_random(RANDOM_ITEMS);

        // Slow sender, mostly ready receiver.
        wait_idle();
        src_idle_pct = 71;
        snk_idle_pct = 18;
        run_random(RANDOM_ITEMS);

        // Full rate; a long stall on the result side backs up the input.
        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = 1'b1;
        run_random(RANDOM_ITEMS);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("int8_int4_matmul_tile_tb passed");
        else
            $display("int8_int4_matmul_tile_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmt_pkg.sv
rtl/mmt_if.sv
rtl/mmt_front.sv
rtl/mmt_queue.sv
rtl/mmt_array.sv
rtl/mmt_drain.sv
rtl/int8_int4_matmul_tile.sv
rtl/mmt_checker.sv
sim/int8_int4_matmul_tile_tb.sv
